### rtl/core/fwvsr_pkg.sv
// types and constants shared by the search-and-remove fifo modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fwvsr_pkg;

    // field widths of one item
    localparam int OP_W       = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 5;
    localparam int CNT_W      = 6;
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 48;
    localparam int M_PAD_W    = M_TDATA_W - (CNT_W + POS_W + VALUE_W + STATUS_W);

    localparam int MAX_RESULTS = 32;
    localparam int CNT_MAX     = 63;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH      = 3'd0;
    localparam logic [OP_W-1:0] OP_POP       = 3'd1;
    localparam logic [OP_W-1:0] OP_COUNT     = 3'd2;
    localparam logic [OP_W-1:0] OP_LIST      = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_FIRST = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_ALL   = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        SM_COUNT,
        SM_LIST,
        SM_DROP_IDX,
        SM_DROP_VAL
    } scan_mode_t;

    typedef enum logic [3:0] {
        EM_OK,
        EM_PUSH,
        EM_FULL,
        EM_EMPTY,
        EM_NOTFOUND,
        EM_COUNT,
        EM_POP,
        EM_REMOVE1,
        EM_REMOVEALL
    } emit_kind_t;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        scan_mode_t mode;
        logic       run;
        logic       emit;
        emit_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            occ_zero;
        logic            occ_full;
        logic            n_zero;
        logic            scan_done;
        logic            list_end;
        logic            out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

### rtl/core/fifo_with_value_search_remove.sv
// top level of the compacted fifo with value search and remove
// depends on fwvsr_pkg, fwvsr_ctrl, fwvsr_datapath (and through it fwvsr_ram)
//
//  channel | dir | ports                                   | content
//  s       | in  | s_tvalid s_tready s_tdata s_tuser        | value in tdata, op in tuser
//  m       | out | m_tvalid m_tready m_tdata m_tlast        | status data position match_count, last
//
// push, pop on empty, unknown ops and ops on an empty queue go straight to the result;
// count and pop scan once; removes and list scan again, to compact or list, after a match;
// one ram read port scans one slot a cycle, held only by a list output stall
// reset clears occupancy and control only; stored words are not cleared
// a finished result sits in the output register while the next item is taken;
// a list scan holds on a match until the output register frees
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_value_search_remove #(
    parameter int DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [fwvsr_pkg::S_TDATA_W-1:0]      s_tdata,  // value[31:0]
    input  logic [fwvsr_pkg::S_TUSER_W-1:0]      s_tuser,  // op[2:0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [fwvsr_pkg::M_TDATA_W-1:0]      m_tdata,  // status[1:0] data[33:2]
                                                           // position[38:34]
                                                           // match_count[44:39] zero[47:45]
    output logic                                 m_tlast
);

    fwvsr_pkg::dp_cmd_t cmd;
    fwvsr_pkg::dp_sts_t sts;

    fwvsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fwvsr_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_op    (s_tuser[fwvsr_pkg::OP_W-1:0]),
        .in_value (s_tdata[fwvsr_pkg::VALUE_W-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### rtl/core/fwvsr_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module fwvsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/fwvsr_datapath.sv
// datapath: entry ram, occupancy, scan pointers, match counter, result register
// depends on fwvsr_pkg and fwvsr_ram
`timescale 1ns / 1ps
`default_nettype none

module fwvsr_datapath #(
    parameter int DEPTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fwvsr_pkg::dp_cmd_t                 cmd,
    output fwvsr_pkg::dp_sts_t                 sts,
    input  logic [fwvsr_pkg::OP_W-1:0]         in_op,
    input  logic signed [fwvsr_pkg::VALUE_W-1:0] in_value,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fwvsr_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [fwvsr_pkg::OP_W-1:0]           op_reg, op_next;
    logic signed [fwvsr_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [CW-1:0]                        occ_reg, occ_next;
    fwvsr_pkg::scan_mode_t                mode_reg, mode_next;
    logic [CW-1:0]                        ptr_reg, ptr_next;
    logic [AW-1:0]                        tag_reg, tag_next;
    logic                                 tag_valid_reg, tag_valid_next;
    logic [CW-1:0]                        n_reg, n_next;
    logic                                 found_reg, found_next;
    logic [AW-1:0]                        first_reg, first_next;
    logic [CW-1:0]                        w_reg, w_next;
    logic [CW-1:0]                        k_reg, k_next;
    logic signed [fwvsr_pkg::VALUE_W-1:0] head_reg, head_next;

    logic                                   m_valid_reg, m_valid_next;
    logic [fwvsr_pkg::STATUS_W-1:0]         out_status_reg, out_status_next;
    logic signed [fwvsr_pkg::VALUE_W-1:0]   out_data_reg, out_data_next;
    logic [fwvsr_pkg::POS_W-1:0]            out_pos_reg, out_pos_next;
    logic [fwvsr_pkg::CNT_W-1:0]            out_cnt_reg, out_cnt_next;
    logic                                   out_last_reg, out_last_next;

    logic                                 wr_en;
    logic [AW-1:0]                        wr_addr;
    logic signed [fwvsr_pkg::VALUE_W-1:0] wr_data;
    logic [AW-1:0]                        rd_addr;
    logic signed [fwvsr_pkg::VALUE_W-1:0] rd_data;

    logic                          match_raw;
    logic                          stall;
    logic                          keep;
    logic                          out_free;
    logic                          load_out;
    logic                          list_end;
    logic                          list_last;
    logic [CW-1:0]                 lim;
    logic [fwvsr_pkg::CNT_W-1:0]   cnt_sat;

    fwvsr_ram #(
        .WIDTH (fwvsr_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign match_raw = (rd_data == value_reg);
    assign out_free  = !m_valid_reg || m_tready;
    // a list match waits here, re-reading its own slot, until the result register frees
    assign stall     = cmd.run && tag_valid_reg && (mode_reg == fwvsr_pkg::SM_LIST)
                       && match_raw && !out_free;
    assign keep      = (mode_reg == fwvsr_pkg::SM_DROP_IDX) ? (tag_reg != first_reg)
                                                            : !match_raw;
    assign cnt_sat   = (int'(n_reg) > fwvsr_pkg::CNT_MAX) ? fwvsr_pkg::CNT_W'(fwvsr_pkg::CNT_MAX)
                                                         : fwvsr_pkg::CNT_W'(n_reg);
    assign lim       = (int'(n_reg) > fwvsr_pkg::MAX_RESULTS) ? CW'(fwvsr_pkg::MAX_RESULTS)
                                                             : n_reg;
    assign list_last = ((k_reg + CW'(1)) == lim);

    always_comb
    begin
        op_next        = op_reg;
        value_next     = value_reg;
        occ_next       = occ_reg;
        mode_next      = mode_reg;
        ptr_next       = ptr_reg;
        tag_next       = tag_reg;
        tag_valid_next = tag_valid_reg;
        n_next         = n_reg;
        found_next     = found_reg;
        first_next     = first_reg;
        w_next         = w_reg;
        k_next         = k_reg;
        head_next      = head_reg;

        rd_addr  = tag_reg;
        wr_en    = 1'b0;
        wr_addr  = w_reg[AW-1:0];
        wr_data  = rd_data;
        load_out = 1'b0;
        list_end = 1'b0;

        out_status_next = fwvsr_pkg::STAT_OK;
        out_data_next   = '0;
        out_pos_next    = '0;
        out_cnt_next    = '0;
        out_last_next   = 1'b1;

        if (cmd.load)
        begin
            op_next    = in_op;
            value_next = in_value;
        end

        if (cmd.scan_start)
        begin
            mode_next      = cmd.mode;
            ptr_next       = '0;
            tag_valid_next = 1'b0;
            w_next         = '0;
            k_next         = '0;
            if (cmd.mode == fwvsr_pkg::SM_COUNT)
            begin
                n_next     = '0;
                found_next = 1'b0;
            end
            // pop drops the head slot
            if (op_reg == fwvsr_pkg::OP_POP)
            begin
                first_next = '0;
            end
        end

        if (cmd.run)
        begin
            // issue side of the read pipeline
            if (!stall)
            begin
                if (ptr_reg < occ_reg)
                begin
                    rd_addr        = ptr_reg[AW-1:0];
                    ptr_next       = ptr_reg + CW'(1);
                    tag_next       = ptr_reg[AW-1:0];
                    tag_valid_next = 1'b1;
                end
                else
                begin
                    tag_valid_next = 1'b0;
                end
            end

            // compare side, one stored word a cycle while no list stall holds
            if (tag_valid_reg)
            begin
                case (mode_reg) inside
                    fwvsr_pkg::SM_COUNT:
                    begin
                        if (match_raw)
                        begin
                            n_next = n_reg + CW'(1);
                            if (!found_reg)
                            begin
                                found_next = 1'b1;
                                first_next = tag_reg;
                            end
                        end
                    end
                    fwvsr_pkg::SM_LIST:
                    begin
                        if (match_raw && out_free)
                        begin
                            load_out      = 1'b1;
                            out_pos_next  = fwvsr_pkg::POS_W'(tag_reg);
                            out_cnt_next  = cnt_sat;
                            out_last_next = list_last;
                            k_next        = k_reg + CW'(1);
                            list_end      = list_last;
                        end
                    end
                    fwvsr_pkg::SM_DROP_IDX, fwvsr_pkg::SM_DROP_VAL:
                    begin
                        if (tag_reg == '0)
                        begin
                            head_next = rd_data;
                        end
                        // write index never passes the read index, so no overlap
                        if (keep)
                        begin
                            wr_en  = 1'b1;
                            w_next = w_reg + CW'(1);
                        end
                    end
                endcase
            end
        end

        if (cmd.emit)
        begin
            load_out = 1'b1;
            unique case (cmd.kind)
                fwvsr_pkg::EM_OK:
                begin
                    out_status_next = fwvsr_pkg::STAT_OK;
                end
                fwvsr_pkg::EM_PUSH:
                begin
                    wr_en        = 1'b1;
                    wr_addr      = occ_reg[AW-1:0];
                    wr_data      = value_reg;
                    occ_next     = occ_reg + CW'(1);
                    out_pos_next = fwvsr_pkg::POS_W'(occ_reg);
                end
                fwvsr_pkg::EM_FULL:
                begin
                    out_status_next = fwvsr_pkg::STAT_FULL;
                end
                fwvsr_pkg::EM_EMPTY:
                begin
                    out_status_next = fwvsr_pkg::STAT_EMPTY;
                end
                fwvsr_pkg::EM_NOTFOUND:
                begin
                    out_status_next = fwvsr_pkg::STAT_NOTFOUND;
                end
                fwvsr_pkg::EM_COUNT:
                begin
                    out_cnt_next = cnt_sat;
                end
                fwvsr_pkg::EM_POP:
                begin
                    occ_next      = w_reg;
                    out_data_next = head_reg;
                end
                fwvsr_pkg::EM_REMOVE1:
                begin
                    occ_next     = w_reg;
                    out_pos_next = fwvsr_pkg::POS_W'(first_reg);
                    out_cnt_next = fwvsr_pkg::CNT_W'(1);
                end
                fwvsr_pkg::EM_REMOVEALL:
                begin
                    occ_next     = w_reg;
                    out_cnt_next = cnt_sat;
                end
                default:
                begin
                    out_status_next = fwvsr_pkg::STAT_OK;
                end
            endcase
        end

        if (load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            tag_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            tag_valid_reg <= tag_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        value_reg <= value_next;
        mode_reg  <= mode_next;
        ptr_reg   <= ptr_next;
        tag_reg   <= tag_next;
        n_reg     <= n_next;
        found_reg <= found_next;
        first_reg <= first_next;
        w_reg     <= w_next;
        k_reg     <= k_next;
        head_reg  <= head_next;
        if (load_out)
        begin
            out_status_reg <= out_status_next;
            out_data_reg   <= out_data_next;
            out_pos_reg    <= out_pos_next;
            out_cnt_reg    <= out_cnt_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign sts.op        = op_reg;
    assign sts.occ_zero  = (occ_reg == '0);
    assign sts.occ_full  = (occ_reg == CW'(DEPTH));
    assign sts.n_zero    = (n_reg == '0);
    assign sts.scan_done = !tag_valid_reg && (ptr_reg == occ_reg);
    assign sts.list_end  = list_end;
    assign sts.out_free  = out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{fwvsr_pkg::M_PAD_W{1'b0}}, out_cnt_reg, out_pos_reg,
                       out_data_reg, out_status_reg};

endmodule

`default_nettype wire

### rtl/core/fwvsr_ctrl.sv
// controller: sequences decode, count pass, list pass, compaction pass and result
// depends on fwvsr_pkg
`timescale 1ns / 1ps
`default_nettype none

module fwvsr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  fwvsr_pkg::dp_sts_t sts,
    output fwvsr_pkg::dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_COUNT,
        S_LIST,
        S_COMPACT,
        S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    fwvsr_pkg::emit_kind_t kind_reg, kind_next;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cmd            = '0;
        cmd.mode       = fwvsr_pkg::SM_COUNT;
        cmd.kind       = kind_reg;
        s_tready       = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                unique case (sts.op) inside
                    fwvsr_pkg::OP_PUSH:
                    begin
                        kind_next  = sts.occ_full ? fwvsr_pkg::EM_FULL : fwvsr_pkg::EM_PUSH;
                        state_next = S_EMIT;
                    end
                    fwvsr_pkg::OP_POP:
                    begin
                        if (sts.occ_zero)
                        begin
                            kind_next  = fwvsr_pkg::EM_EMPTY;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.mode       = fwvsr_pkg::SM_DROP_IDX;
                            kind_next      = fwvsr_pkg::EM_POP;
                            state_next     = S_COMPACT;
                        end
                    end
                    fwvsr_pkg::OP_COUNT, fwvsr_pkg::OP_LIST,
                    fwvsr_pkg::OP_REM_FIRST, fwvsr_pkg::OP_REM_ALL:
                    begin
                        if (sts.occ_zero)
                        begin
                            kind_next  = fwvsr_pkg::EM_EMPTY;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.mode       = fwvsr_pkg::SM_COUNT;
                            state_next     = S_COUNT;
                        end
                    end
                    default:
                    begin
                        kind_next  = fwvsr_pkg::EM_OK;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_COUNT:
            begin
                cmd.run = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.run = 1'b0;
                    if (sts.op == fwvsr_pkg::OP_COUNT)
                    begin
                        kind_next  = fwvsr_pkg::EM_COUNT;
                        state_next = S_EMIT;
                    end
                    else if (sts.n_zero)
                    begin
                        kind_next  = fwvsr_pkg::EM_NOTFOUND;
                        state_next = S_EMIT;
                    end
                    else if (sts.op == fwvsr_pkg::OP_LIST)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.mode       = fwvsr_pkg::SM_LIST;
                        state_next     = S_LIST;
                    end
                    else if (sts.op == fwvsr_pkg::OP_REM_FIRST)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.mode       = fwvsr_pkg::SM_DROP_IDX;
                        kind_next      = fwvsr_pkg::EM_REMOVE1;
                        state_next     = S_COMPACT;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.mode       = fwvsr_pkg::SM_DROP_VAL;
                        kind_next      = fwvsr_pkg::EM_REMOVEALL;
                        state_next     = S_COMPACT;
                    end
                end
            end
            S_LIST:
            begin
                cmd.run = 1'b1;
                // results leave straight from the scan; done after the final one
                if (sts.list_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_COMPACT:
            begin
                cmd.run = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.run    = 1'b0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= fwvsr_pkg::EM_OK;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

`default_nettype wire
